@@ src/imu_freefall_motion_rest_rezero_defines.svh @@
// ============================================================================
// IMU free-fall / motion / rest detector: assertion macros
// Concurrent assertion wrappers shared by the RTL. Defining ASSERT_OFF
// turns every check into an empty statement.
// ============================================================================
`ifndef IMU_FREEFALL_MOTION_REST_REZERO_DEFINES_SVH
`define IMU_FREEFALL_MOTION_REST_REZERO_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked on every rising clk edge, ignored while rst_n is low.
`define IMU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clk edge, reset included.
`define IMU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMU_ASSERT(label, prop, msg)
`define IMU_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ src/imu_ffr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imu_ffr_pkg
// Shared constants, payload types and control structs of the IMU
// free-fall, motion and rest detector.
// ============================================================================
package imu_ffr_pkg;

    localparam int RUN_BITS_DEF        = 8;
    localparam int REST_COUNT_BITS_DEF = 9;

    localparam int DATA_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int SAMPLES_W   = 8;
    localparam int COOLDOWN_W  = 8;
    localparam int NUM_AXES    = 3;
    // Squarer operand holds a 16-bit magnitude or the 17-bit upper band edge.
    localparam int SQ_OP_W     = 17;
    localparam int SQ_W        = 2 * SQ_OP_W;
    // Sum of three squares needs two more bits.
    localparam int MAG_W       = SQ_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREEFALL_LEVEL   = 3'd0,
        CFG_ONE_G_LEVEL      = 3'd1,
        CFG_MOTION_BAND      = 3'd2,
        CFG_STILL_GYRO_LEVEL = 3'd3,
        CFG_FREEFALL_SAMPLES = 3'd4,
        CFG_MOTION_SAMPLES   = 3'd5,
        CFG_REST_WINDOW      = 3'd6,
        CFG_COOLDOWN_SAMPLES = 3'd7
    } cfg_reg_e;

    localparam logic [CFG_W-1:0]      RST_FREEFALL_LEVEL   = 16'd6554;
    localparam logic [CFG_W-1:0]      RST_ONE_G_LEVEL      = 16'd16384;
    localparam logic [CFG_W-1:0]      RST_MOTION_BAND      = 16'd4096;
    localparam logic [CFG_W-1:0]      RST_STILL_GYRO_LEVEL = 16'd33;
    localparam logic [SAMPLES_W-1:0]  RST_FREEFALL_SAMPLES = 8'd2;
    localparam logic [SAMPLES_W-1:0]  RST_MOTION_SAMPLES   = 8'd2;
    localparam logic [SAMPLES_W-1:0]  RST_REST_WINDOW      = 8'd50;
    localparam logic [COOLDOWN_W-1:0] RST_COOLDOWN_SAMPLES = 8'd100;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_z;
    } sample_t;

    typedef struct packed {
        logic                     freefall;
        logic                     motion;
        logic                     still;
        logic                     rezero_apply;
        logic signed [DATA_W-1:0] resid_x;
        logic signed [DATA_W-1:0] resid_y;
        logic signed [DATA_W-1:0] resid_z;
    } result_t;

    typedef struct packed {
        logic acc_add;
        logic acc_clr;
        logic div_start;
    } lane_ctrl_t;

    typedef struct packed {
        logic cap_accel;
        logic cap_gyro;
        logic cap_cmp;
    } merge_ctrl_t;

    typedef struct packed {
        logic low;
        logic off_band;
        logic gyro_quiet;
    } merge_flags_t;

    function automatic logic [SQ_OP_W-1:0] abs_mag(input logic signed [DATA_W-1:0] v);
        logic signed [SQ_OP_W-1:0] wide;
        wide = SQ_OP_W'(v);
        return wide[SQ_OP_W-1] ? SQ_OP_W'(-wide) : SQ_OP_W'(wide);
    endfunction

endpackage

@@ src/imu_ffr_stream_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imu_ffr_stream_if
// Valid/ready channel carrying one payload per transaction.
// ============================================================================
interface imu_ffr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/imu_freefall_motion_rest_rezero.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imu_freefall_motion_rest_rezero
// Free-fall, motion and rest detector with gyro bias re-zero over a window.
// ============================================================================
// Flow: a new sample is taken only once the previous result is in the output
//   register; a window close adds the divider's run, one quotient bit per
//   cycle in each lane.
// Reset: rst_n clears run counters, rest sums, count and cooldown and loads
//   the register defaults; the sequencer returns to idle, ready for a sample.
module imu_freefall_motion_rest_rezero
    import imu_ffr_pkg::*;
#(
    parameter int RUN_BITS        = RUN_BITS_DEF,
    parameter int REST_COUNT_BITS = REST_COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    imu_ffr_stream_if.sink       samples,
    imu_ffr_stream_if.source     results
);

`include "imu_freefall_motion_rest_rezero_defines.svh"

    // Common widths for comparing run lengths and the rest count against
    // the 8-bit sample registers.
    localparam int RUN_CMP_W   = (RUN_BITS > SAMPLES_W) ? RUN_BITS : SAMPLES_W;
    localparam int COUNT_CMP_W = (REST_COUNT_BITS > SAMPLES_W) ? REST_COUNT_BITS : SAMPLES_W;
    localparam logic [RUN_BITS-1:0]        RUN_MAX   = {RUN_BITS{1'b1}};
    localparam logic [REST_COUNT_BITS-1:0] COUNT_MAX = {REST_COUNT_BITS{1'b1}};

    // The sequencer walks one sample through the lanes: three squaring
    // passes share each lane's multiplier (accel, gyro, thresholds), one more
    // squares the gyro level, then compare, update and window check.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_ACC,
        S_SQ_GYR,
        S_SQ_THR,
        S_SQ_STL,
        S_CMP,
        S_UPDATE,
        S_CHECK,
        S_DIV,
        S_OUT
    } state_t;

    // Configuration registers.
    logic [CFG_W-1:0]      freefall_level_reg;
    logic [CFG_W-1:0]      one_g_level_reg;
    logic [CFG_W-1:0]      motion_band_reg;
    logic [CFG_W-1:0]      still_gyro_level_reg;
    logic [SAMPLES_W-1:0]  freefall_samples_reg;
    logic [SAMPLES_W-1:0]  motion_samples_reg;
    logic [SAMPLES_W-1:0]  rest_window_reg;
    logic [COOLDOWN_W-1:0] cooldown_samples_reg;

    // Sequencer and detector state.
    state_t                     state_reg;
    sample_t                    sample_reg;
    logic [SQ_W-1:0]            freefall_sq_reg;
    logic [SQ_W-1:0]            band_hi_sq_reg;
    logic [SQ_W-1:0]            band_lo_sq_reg;
    logic [RUN_BITS-1:0]        low_run_reg;
    logic [RUN_BITS-1:0]        off_run_reg;
    logic [REST_COUNT_BITS-1:0] rest_count_reg;
    logic [COOLDOWN_W-1:0]      cooldown_reg;
    logic                       freefall_reg;
    logic                       motion_reg;
    logic                       still_reg;
    logic                       closed_reg;
    logic                       out_valid_reg;
    result_t                    out_reg;

    // Lane and merge wiring.
    logic signed [DATA_W-1:0] accel_axis [NUM_AXES];
    logic signed [DATA_W-1:0] gyro_axis  [NUM_AXES];
    logic [SQ_OP_W-1:0]       sq_op      [NUM_AXES];
    logic [SQ_W-1:0]          lane_sq    [NUM_AXES];
    logic signed [DATA_W-1:0] lane_resid [NUM_AXES];
    logic [NUM_AXES-1:0]      lane_big;
    logic [NUM_AXES-1:0]      lane_done;
    lane_ctrl_t               lane_ctrl;
    merge_ctrl_t              merge_ctrl;
    merge_flags_t             flags;
    logic                     merge_rezero;

    // Next-state values of the update and window-check steps.
    logic [RUN_BITS-1:0]        low_run_next;
    logic [RUN_BITS-1:0]        off_run_next;
    logic                       freefall_next;
    logic                       motion_next;
    logic                       still_next;
    logic                       count_room;
    logic [SAMPLES_W-1:0]       window_len;
    logic                       win_close;
    logic                       band_lo_en;
    logic                       out_free;
    logic                       rezero_now;
    result_t                    out_next;

    // ------------------------------------------------------------------
    // Configuration port: the user must write it only while the block is idle; the block itself does not enforce this.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freefall_level_reg   <= RST_FREEFALL_LEVEL;
            one_g_level_reg      <= RST_ONE_G_LEVEL;
            motion_band_reg      <= RST_MOTION_BAND;
            still_gyro_level_reg <= RST_STILL_GYRO_LEVEL;
            freefall_samples_reg <= RST_FREEFALL_SAMPLES;
            motion_samples_reg   <= RST_MOTION_SAMPLES;
            rest_window_reg      <= RST_REST_WINDOW;
            cooldown_samples_reg <= RST_COOLDOWN_SAMPLES;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_FREEFALL_LEVEL:   freefall_level_reg   <= cfg_wr_data;
                CFG_ONE_G_LEVEL:      one_g_level_reg      <= cfg_wr_data;
                CFG_MOTION_BAND:      motion_band_reg      <= cfg_wr_data;
                CFG_STILL_GYRO_LEVEL: still_gyro_level_reg <= cfg_wr_data;
                CFG_FREEFALL_SAMPLES: freefall_samples_reg <= cfg_wr_data[SAMPLES_W-1:0];
                CFG_MOTION_SAMPLES:   motion_samples_reg   <= cfg_wr_data[SAMPLES_W-1:0];
                CFG_REST_WINDOW:      rest_window_reg      <= cfg_wr_data[SAMPLES_W-1:0];
                CFG_COOLDOWN_SAMPLES: cooldown_samples_reg <= cfg_wr_data[COOLDOWN_W-1:0];
                default:              freefall_level_reg   <= freefall_level_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Squarer operands. Each lane owns one multiplier; the sequencer feeds it the
    // accel axis, the gyro axis, one threshold, then (lane 0 only) the gyro level.
    // The lower band edge is only meaningful when one g exceeds the band.
    // ------------------------------------------------------------------
    assign accel_axis[0] = sample_reg.accel_x;
    assign accel_axis[1] = sample_reg.accel_y;
    assign accel_axis[2] = sample_reg.accel_z;
    assign gyro_axis[0]  = sample_reg.gyro_x;
    assign gyro_axis[1]  = sample_reg.gyro_y;
    assign gyro_axis[2]  = sample_reg.gyro_z;

    assign band_lo_en = one_g_level_reg > motion_band_reg;

    always_comb
    begin
        unique case (state_reg)
            S_SQ_ACC:
            begin
                sq_op[0] = abs_mag(accel_axis[0]);
                sq_op[1] = abs_mag(accel_axis[1]);
                sq_op[2] = abs_mag(accel_axis[2]);
            end
            S_SQ_GYR:
            begin
                sq_op[0] = abs_mag(gyro_axis[0]);
                sq_op[1] = abs_mag(gyro_axis[1]);
                sq_op[2] = abs_mag(gyro_axis[2]);
            end
            S_SQ_THR:
            begin
                sq_op[0] = SQ_OP_W'(freefall_level_reg);
                sq_op[1] = SQ_OP_W'(one_g_level_reg) + SQ_OP_W'(motion_band_reg);
                sq_op[2] = SQ_OP_W'(one_g_level_reg - motion_band_reg);
            end
            S_SQ_STL:
            begin
                sq_op[0] = SQ_OP_W'(still_gyro_level_reg);
                sq_op[1] = '0;
                sq_op[2] = '0;
            end
            default:
            begin
                sq_op[0] = '0;
                sq_op[1] = '0;
                sq_op[2] = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Lanes, one per axis, and the merging stage.
    // ------------------------------------------------------------------
    for (genvar ax = 0; ax < NUM_AXES; ax++)
    begin : g_lane
        imu_ffr_lane #(
            .REST_COUNT_BITS (REST_COUNT_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (lane_ctrl),
            .sq_op     (sq_op[ax]),
            .gyro      (gyro_axis[ax]),
            .count     (rest_count_reg),
            .sq        (lane_sq[ax]),
            .resid     (lane_resid[ax]),
            .resid_big (lane_big[ax]),
            .div_done  (lane_done[ax])
        );
    end

    // The lane squares are registered, so each capture sits one state behind
    // the matching squaring pass.
    assign merge_ctrl.cap_accel = state_reg == S_SQ_GYR;
    assign merge_ctrl.cap_gyro  = state_reg == S_SQ_THR;
    assign merge_ctrl.cap_cmp   = state_reg == S_CMP;

    imu_ffr_merge u_merge (
        .clk         (clk),
        .ctrl        (merge_ctrl),
        .sq_x        (lane_sq[0]),
        .sq_y        (lane_sq[1]),
        .sq_z        (lane_sq[2]),
        .freefall_sq (freefall_sq_reg),
        .band_hi_sq  (band_hi_sq_reg),
        .band_lo_sq  (band_lo_sq_reg),
        .band_lo_en  (band_lo_en),
        .still_sq    (lane_sq[0]),
        .lane_big    (lane_big),
        .flags       (flags),
        .rezero      (merge_rezero)
    );

    // ------------------------------------------------------------------
    // Run counters saturate at all ones; a sample register of zero makes
    // the event fire on every sample. Motion yields to free-fall, and a
    // still sample needs neither event plus a quiet gyro.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (flags.low)
        begin
            low_run_next = (low_run_reg == RUN_MAX) ? low_run_reg : low_run_reg + 1'b1;
        end
        else
        begin
            low_run_next = '0;
        end
        if (flags.off_band)
        begin
            off_run_next = (off_run_reg == RUN_MAX) ? off_run_reg : off_run_reg + 1'b1;
        end
        else
        begin
            off_run_next = '0;
        end
    end

    assign freefall_next = RUN_CMP_W'(low_run_next) >= RUN_CMP_W'(freefall_samples_reg);
    assign motion_next   = (RUN_CMP_W'(off_run_next) >= RUN_CMP_W'(motion_samples_reg)) &&
                           !freefall_next;
    assign still_next    = !motion_next && !freefall_next && flags.gyro_quiet;
    // A full count keeps reporting still samples but stops summing them.
    assign count_room    = rest_count_reg != COUNT_MAX;

    // A window of zero behaves as a window of one so the divisor is never zero.
    assign window_len = (rest_window_reg == '0) ? SAMPLES_W'(1) : rest_window_reg;
    assign win_close  = (COUNT_CMP_W'(rest_count_reg) >= COUNT_CMP_W'(window_len)) &&
                        (cooldown_reg == '0);

    // The divider latches the sums in the same cycle that clears them.
    assign lane_ctrl.acc_add   = (state_reg == S_UPDATE) && still_next && count_room;
    assign lane_ctrl.acc_clr   = ((state_reg == S_UPDATE) && !still_next) ||
                                 ((state_reg == S_CHECK) && win_close);
    assign lane_ctrl.div_start = (state_reg == S_CHECK) && win_close;

    // ------------------------------------------------------------------
    // Result assembly and handshakes. The output register frees the input
    // side: a new sample is taken while a finished result waits.
    // ------------------------------------------------------------------
    assign rezero_now = closed_reg && merge_rezero;

    always_comb
    begin
        out_next.freefall     = freefall_reg;
        out_next.motion       = motion_reg;
        out_next.still        = still_reg;
        out_next.rezero_apply = rezero_now;
        out_next.resid_x      = rezero_now ? lane_resid[0] : '0;
        out_next.resid_y      = rezero_now ? lane_resid[1] : '0;
        out_next.resid_z      = rezero_now ? lane_resid[2] : '0;
    end

    assign out_free        = !out_valid_reg || results.ready;
    assign samples.ready   = state_reg == S_IDLE;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    // ------------------------------------------------------------------
    // Sequencer with its state and registered outputs.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            low_run_reg    <= '0;
            off_run_reg    <= '0;
            rest_count_reg <= '0;
            cooldown_reg   <= '0;
            freefall_reg   <= 1'b0;
            motion_reg     <= 1'b0;
            still_reg      <= 1'b0;
            closed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new result may replace one that leaves in the same cycle.
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (samples.valid)
                    begin
                        sample_reg <= samples.payload;
                        state_reg  <= S_SQ_ACC;
                    end
                end
                S_SQ_ACC:
                begin
                    state_reg <= S_SQ_GYR;
                end
                S_SQ_GYR:
                begin
                    state_reg <= S_SQ_THR;
                end
                S_SQ_THR:
                begin
                    state_reg <= S_SQ_STL;
                end
                S_SQ_STL:
                begin
                    freefall_sq_reg <= lane_sq[0];
                    band_hi_sq_reg  <= lane_sq[1];
                    band_lo_sq_reg  <= lane_sq[2];
                    state_reg       <= S_CMP;
                end
                S_CMP:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    low_run_reg  <= low_run_next;
                    off_run_reg  <= off_run_next;
                    freefall_reg <= freefall_next;
                    motion_reg   <= motion_next;
                    still_reg    <= still_next;
                    if (cooldown_reg != '0)
                    begin
                        cooldown_reg <= cooldown_reg - 1'b1;
                    end
                    if (!still_next)
                    begin
                        rest_count_reg <= '0;
                    end
                    else if (count_room)
                    begin
                        rest_count_reg <= rest_count_reg + 1'b1;
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    closed_reg <= win_close;
                    if (win_close)
                    begin
                        rest_count_reg <= '0;
                        cooldown_reg   <= cooldown_samples_reg;
                        state_reg      <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (&lane_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= out_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checks on the detector logic.
    // ------------------------------------------------------------------
    logic chk_both;
    logic chk_still;
    logic chk_big;
    logic chk_zero;
    logic chk_restart;

    assign chk_both    = out_reg.freefall && out_reg.motion;
    assign chk_still   = !out_reg.still || (!out_reg.freefall && !out_reg.motion);
    assign chk_big     = !out_reg.rezero_apply ||
                         (out_reg.resid_x >= 16'sd2) || (out_reg.resid_x <= -16'sd2) ||
                         (out_reg.resid_y >= 16'sd2) || (out_reg.resid_y <= -16'sd2) ||
                         (out_reg.resid_z >= 16'sd2) || (out_reg.resid_z <= -16'sd2);
    assign chk_zero    = out_reg.rezero_apply ||
                         ((out_reg.resid_x == '0) && (out_reg.resid_y == '0) &&
                          (out_reg.resid_z == '0));
    assign chk_restart = (rest_count_reg == '0) && (cooldown_reg == cooldown_samples_reg);

    `IMU_ASSERT_ALWAYS(a_ff_motion_excl, out_valid_reg |-> !chk_both, "free-fall with motion")
    `IMU_ASSERT(a_still_clean, out_valid_reg |-> chk_still, "still sample during an event")
    `IMU_ASSERT(a_rezero_big, out_valid_reg |-> chk_big, "rezero without a large residual")
    `IMU_ASSERT(a_no_rezero_zero, out_valid_reg |-> chk_zero, "residual shown without rezero")
    `IMU_ASSERT(a_close_restart, lane_ctrl.div_start |=> chk_restart, "window did not restart")

endmodule

@@ src/imu_ffr_lane.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imu_ffr_lane
// One axis: a registered squarer, the rest sum accumulator and a restoring
// divider that averages the sum over the still-sample count.
// ============================================================================
module imu_ffr_lane
    import imu_ffr_pkg::*;
#(
    parameter int REST_COUNT_BITS = REST_COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic [SQ_OP_W-1:0]         sq_op,
    input  logic signed [DATA_W-1:0]   gyro,
    input  logic [REST_COUNT_BITS-1:0] count,
    output logic [SQ_W-1:0]            sq,
    output logic signed [DATA_W-1:0]   resid,
    output logic                       resid_big,
    output logic                       div_done
);

    localparam int SUM_W = DATA_W + REST_COUNT_BITS + 1;
    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam int REM_W = REST_COUNT_BITS + 1;

    logic [SQ_W-1:0]            sq_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]           quo_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [REST_COUNT_BITS-1:0] den_reg;
    logic                       neg_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic [SUM_W-1:0]  sum_mag;
    logic [REM_W-1:0]  rem_shift;
    logic              fits;
    logic [DATA_W-1:0] quo_low;

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_op * sq_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.acc_clr)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            sum_reg <= sum_reg + SUM_W'(gyro);
        end
    end

    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            quo_reg <= sum_mag;
            rem_reg <= '0;
            den_reg <= count;
            neg_reg <= sum_reg[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
        end
    end

    assign quo_low   = quo_reg[DATA_W-1:0];
    assign sq        = sq_reg;
    assign resid     = neg_reg ? $signed(-quo_low) : $signed(quo_low);
    assign resid_big = |quo_reg[SUM_W-1:1];
    assign div_done  = done_reg;

endmodule

@@ src/imu_ffr_merge.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imu_ffr_merge
// Adds the three lane squares into accel and gyro magnitudes, compares them
// with the squared thresholds and combines the lane residual flags.
// ============================================================================
module imu_ffr_merge
    import imu_ffr_pkg::*;
(
    input  logic                clk,
    input  merge_ctrl_t         ctrl,
    input  logic [SQ_W-1:0]     sq_x,
    input  logic [SQ_W-1:0]     sq_y,
    input  logic [SQ_W-1:0]     sq_z,
    input  logic [SQ_W-1:0]     freefall_sq,
    input  logic [SQ_W-1:0]     band_hi_sq,
    input  logic [SQ_W-1:0]     band_lo_sq,
    input  logic                band_lo_en,
    input  logic [SQ_W-1:0]     still_sq,
    input  logic [NUM_AXES-1:0] lane_big,
    output merge_flags_t        flags,
    output logic                rezero
);

    logic [MAG_W-1:0] sq_sum;
    logic [MAG_W-1:0] accel_mag_reg;
    logic [MAG_W-1:0] gyro_mag_reg;
    merge_flags_t     flags_reg;

    assign sq_sum = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_accel)
        begin
            accel_mag_reg <= sq_sum;
        end
        if (ctrl.cap_gyro)
        begin
            gyro_mag_reg <= sq_sum;
        end
        if (ctrl.cap_cmp)
        begin
            flags_reg.low        <= accel_mag_reg < MAG_W'(freefall_sq);
            flags_reg.off_band   <= (accel_mag_reg > MAG_W'(band_hi_sq)) ||
                                    (band_lo_en && (accel_mag_reg < MAG_W'(band_lo_sq)));
            flags_reg.gyro_quiet <= gyro_mag_reg < MAG_W'(still_sq);
        end
    end

    assign flags  = flags_reg;
    assign rezero = |lane_big;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top: free-fall, motion and rest detector testbench
// Drives sensor samples through the valid/ready channel under random idling
// and backpressure, predicts every result transaction in a scoreboard class
// and compares it field by field. Register settings change between phases,
// while the block is idle, and cover the extremes.
// ============================================================================
module tb_top;
    import imu_ffr_pkg::*;

    // Saturation points of the run counters and the rest count.
    localparam int RUN_MAX        = (1 << RUN_BITS_DEF) - 1;
    localparam int COUNT_MAX      = (1 << REST_COUNT_BITS_DEF) - 1;
    // A residual of this magnitude or more asks for a rezero.
    localparam int REZERO_MIN     = 2;
    // Chance in percent that a side idles in a given cycle.
    localparam int IDLE_PCT       = 37;
    localparam int REPORT_MAX     = 10;
    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Idle time before the verdict; the slowest result is a window close.
    localparam int TAIL_CYCLES    = 40;

    // Local copy of the register file, one field per register.
    typedef struct packed {
        logic [CFG_W-1:0]      ff_level;
        logic [CFG_W-1:0]      one_g;
        logic [CFG_W-1:0]      band;
        logic [CFG_W-1:0]      gyro_level;
        logic [SAMPLES_W-1:0]  ff_need;
        logic [SAMPLES_W-1:0]  motion_need;
        logic [SAMPLES_W-1:0]  window;
        logic [COOLDOWN_W-1:0] cooldown;
    } det_cfg_t;

    // Shapes of generated samples.
    typedef enum int {
        SK_STILL,
        SK_LOW,
        SK_HIGH,
        SK_LOUD,
        SK_NOISE
    } sample_kind_e;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the detector state for every accepted sample and
    // keeps the results that are due, oldest first.
    // ------------------------------------------------------------------------
    class ffr_scoreboard;
        result_t  due_results[$];
        int       mismatches;
        det_cfg_t regs;
        int       low_run;
        int       off_band_run;
        int       rest_samples;
        int       cooldown_left;
        longint   rest_sum [3];

        function new();
            regs.ff_level    = RST_FREEFALL_LEVEL;
            regs.one_g       = RST_ONE_G_LEVEL;
            regs.band        = RST_MOTION_BAND;
            regs.gyro_level  = RST_STILL_GYRO_LEVEL;
            regs.ff_need     = RST_FREEFALL_SAMPLES;
            regs.motion_need = RST_MOTION_SAMPLES;
            regs.window      = RST_REST_WINDOW;
            regs.cooldown    = RST_COOLDOWN_SAMPLES;
            mismatches       = 0;
            low_run          = 0;
            off_band_run     = 0;
            rest_samples     = 0;
            cooldown_left    = 0;
            for (int i = 0; i < NUM_AXES; i++)
                rest_sum[i] = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_FREEFALL_LEVEL:   regs.ff_level    = v;
                CFG_ONE_G_LEVEL:      regs.one_g       = v;
                CFG_MOTION_BAND:      regs.band        = v;
                CFG_STILL_GYRO_LEVEL: regs.gyro_level  = v;
                CFG_FREEFALL_SAMPLES: regs.ff_need     = v[SAMPLES_W-1:0];
                CFG_MOTION_SAMPLES:   regs.motion_need = v[SAMPLES_W-1:0];
                CFG_REST_WINDOW:      regs.window      = v[SAMPLES_W-1:0];
                CFG_COOLDOWN_SAMPLES: regs.cooldown    = v[COOLDOWN_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the detector by one sample and returns its result.
        function result_t step_detector(sample_t s);
            longint  g [3];
            longint  resid [3];
            longint  ax, ay, az;
            longint  amag2, gmag2, hi, lo, gl;
            int      win;
            logic    ff, mo, st, off_band, apply;
            result_t r;

            ax = longint'(s.accel_x);
            ay = longint'(s.accel_y);
            az = longint'(s.accel_z);
            g[0] = longint'(s.gyro_x);
            g[1] = longint'(s.gyro_y);
            g[2] = longint'(s.gyro_z);
            amag2 = ax * ax + ay * ay + az * az;
            gmag2 = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];

            if (amag2 < longint'(regs.ff_level) * longint'(regs.ff_level)) begin
                if (low_run < RUN_MAX)
                    low_run++;
            end
            else
                low_run = 0;
            ff = (low_run >= int'(regs.ff_need));

            // Band edges around one g; the lower edge only exists above zero.
            hi = longint'(regs.one_g) + longint'(regs.band);
            off_band = (amag2 > hi * hi);
            if (regs.one_g > regs.band) begin
                lo = longint'(regs.one_g) - longint'(regs.band);
                if (amag2 < lo * lo)
                    off_band = 1'b1;
            end
            if (off_band) begin
                if (off_band_run < RUN_MAX)
                    off_band_run++;
            end
            else
                off_band_run = 0;
            mo = (off_band_run >= int'(regs.motion_need)) && !ff;

            if (cooldown_left > 0)
                cooldown_left--;

            gl = longint'(regs.gyro_level);
            st = !mo && !ff && (gmag2 < gl * gl);
            if (st) begin
                if (rest_samples < COUNT_MAX) begin
                    for (int i = 0; i < NUM_AXES; i++)
                        rest_sum[i] += g[i];
                    rest_samples++;
                end
            end
            else begin
                for (int i = 0; i < NUM_AXES; i++)
                    rest_sum[i] = 0;
                rest_samples = 0;
            end

            apply = 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
                resid[i] = 0;
            win = (regs.window == 0) ? 1 : int'(regs.window);
            if (rest_samples >= win && cooldown_left == 0) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    resid[i] = rest_sum[i] / longint'(rest_samples);
                    if (resid[i] >= REZERO_MIN || resid[i] <= -REZERO_MIN)
                        apply = 1'b1;
                    rest_sum[i] = 0;
                end
                rest_samples  = 0;
                cooldown_left = int'(regs.cooldown);
            end

            r.freefall     = ff;
            r.motion       = mo;
            r.still        = st;
            r.rezero_apply = apply;
            r.resid_x      = apply ? DATA_W'(resid[0]) : '0;
            r.resid_y      = apply ? DATA_W'(resid[1]) : '0;
            r.resid_z      = apply ? DATA_W'(resid[2]) : '0;
            return r;
        endfunction

        function void note_sample(sample_t s);
            due_results.push_back(step_detector(s));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: ff=%0b mo=%0b st=%0b rz=%0b r=(%0d,%0d,%0d)",
                             got.freefall, got.motion, got.still, got.rezero_apply,
                             got.resid_x, got.resid_y, got.resid_z);
                return;
            end
            want = due_results.pop_front();
            if (got.freefall !== want.freefall || got.motion !== want.motion ||
                got.still !== want.still || got.rezero_apply !== want.rezero_apply ||
                got.resid_x !== want.resid_x || got.resid_y !== want.resid_y ||
                got.resid_z !== want.resid_z) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: exp ff=%0b mo=%0b st=%0b rz=%0b r=(%0d,%0d,%0d) %s",
                             want.freefall, want.motion, want.still, want.rezero_apply,
                             want.resid_x, want.resid_y, want.resid_z, "");
                if (mismatches <= REPORT_MAX)
                    $display("          got ff=%0b mo=%0b st=%0b rz=%0b r=(%0d,%0d,%0d)",
                             got.freefall, got.motion, got.still, got.rezero_apply,
                             got.resid_x, got.resid_y, got.resid_z);
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    // While this is set neither side idles.
    bit steady = 1'b0;
    int quiet_cycles = 0;

    ffr_scoreboard sb = new();

    imu_ffr_stream_if #(.payload_t(sample_t)) sample_ch ();
    imu_ffr_stream_if #(.payload_t(result_t)) result_ch ();

    imu_freefall_motion_rest_rezero dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .samples     (sample_ch),
        .results     (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic sample_fire;
    logic result_fire;
    assign sample_fire = sample_ch.valid && sample_ch.ready;
    assign result_fire = result_ch.valid && result_ch.ready;

    // The result side stalls at random, except in the steady stretch.
    always @(posedge clk)
    begin
        result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: every accepted sample is predicted and every accepted result
    // is checked at the same edge at which its transaction completes. The
    // values read here are the ones from before the edge, so the order of
    // processes within the time step does not matter.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (sample_fire)
                sb.note_sample(sample_ch.payload);
            if (result_fire)
                sb.check_result(result_ch.payload);
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        if (rst_n && !sample_fire && !result_fire)
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sample construction.
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] clip16(int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[DATA_W-1:0];
    endfunction

    // Uniform integer in [-h, h].
    function automatic int srand(int h);
        return int'($urandom_range(0, 2 * h)) - h;
    endfunction

    function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int gz);
        sample_t s;
        s.accel_x = clip16(ax);
        s.accel_y = clip16(ay);
        s.accel_z = clip16(az);
        s.gyro_x  = clip16(gx);
        s.gyro_y  = clip16(gy);
        s.gyro_z  = clip16(gz);
        return s;
    endfunction

    // Builds one sample of the given shape against the current registers.
    // Still samples hold one g on one axis and keep every gyro axis within
    // half the still level, so that the gyro magnitude stays below it.
    function automatic sample_t build_sample(sample_kind_e kind, int bx, int by,
                                             int bz, int jit);
        sample_t s;
        int      axis;
        int      mag;
        int      half;
        int      side;
        s = '0;
        case (kind)
            SK_STILL: begin
                axis = $urandom_range(0, 2);
                mag  = int'(sb.regs.one_g) + srand(int'(sb.regs.band) / 4);
                if ($urandom_range(0, 1) != 0)
                    mag = -mag;
                side = int'(sb.regs.band) / 8;
                s = mk(axis == 0 ? mag : srand(side), axis == 1 ? mag : srand(side),
                       axis == 2 ? mag : srand(side),
                       bx + srand(jit), by + srand(jit), bz + srand(jit));
            end
            SK_LOW: begin
                half = int'(sb.regs.ff_level) / 2;
                s = mk(srand(half), srand(half), srand(half),
                       srand(32768), srand(32768), srand(32768));
            end
            SK_HIGH: begin
                axis = $urandom_range(0, 2);
                mag  = int'(sb.regs.one_g) + int'(sb.regs.band) + 1 +
                       int'($urandom_range(0, 4000));
                if ($urandom_range(0, 1) != 0)
                    mag = -mag;
                s = mk(axis == 0 ? mag : srand(1000), axis == 1 ? mag : srand(1000),
                       axis == 2 ? mag : srand(1000),
                       bx + srand(jit), by + srand(jit), bz + srand(jit));
            end
            SK_LOUD: begin
                s = mk(($urandom_range(0, 1) != 0 ? -1 : 1) * (25000 + $urandom_range(0, 7767)),
                       ($urandom_range(0, 1) != 0 ? -1 : 1) * (25000 + $urandom_range(0, 7767)),
                       ($urandom_range(0, 1) != 0 ? -1 : 1) * (25000 + $urandom_range(0, 7768)),
                       srand(32768), srand(32768), srand(32768));
            end
            default: begin
                s = {$urandom(), $urandom(), $urandom()};
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. All of them are entered and left at a rising edge.
    // ------------------------------------------------------------------------

    // Offers one sample and returns at the edge at which it was accepted.
    // Valid stays high into the next sample when no idle cycle is drawn.
    task automatic send_sample(input sample_t s);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        end
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_burst(input sample_kind_e kind, input int len, input int bx,
                              input int by, input int bz, input int jit);
        for (int i = 0; i < len; i++)
            send_sample(build_sample(kind, bx, by, bz, jit));
    endtask

    // Stops offering samples and waits until every result has come back.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One register write per edge. The enable is left high so that writes
    // can follow each other without a second assignment in the same step.
    task automatic put_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    // Writes the whole register file; only called while the block is idle.
    task automatic apply_cfg(input int ff_level, input int one_g, input int band,
                             input int gyro_level, input int ff_need,
                             input int motion_need, input int window,
                             input int cooldown);
        put_reg(CFG_FREEFALL_LEVEL, CFG_W'(ff_level));
        put_reg(CFG_ONE_G_LEVEL, CFG_W'(one_g));
        put_reg(CFG_MOTION_BAND, CFG_W'(band));
        put_reg(CFG_STILL_GYRO_LEVEL, CFG_W'(gyro_level));
        put_reg(CFG_FREEFALL_SAMPLES, CFG_W'(ff_need));
        put_reg(CFG_MOTION_SAMPLES, CFG_W'(motion_need));
        put_reg(CFG_REST_WINDOW, CFG_W'(window));
        put_reg(CFG_COOLDOWN_SAMPLES, CFG_W'(cooldown));
        cfg_wr_en <= 1'b0;
    endtask

    // Random stimulus shaped like real use: mostly still stretches long
    // enough to close rest windows, mixed with free-fall drops, motion
    // bursts, full-scale shocks and raw noise that break the sequences.
    task automatic run_phase(input int n_items);
        int           sent;
        int           len;
        int           pick;
        int           h;
        int           jit;
        int           bx, by, bz;
        sample_kind_e kind;
        sent = 0;
        while (sent < n_items) begin
            h = int'(sb.regs.gyro_level) / 4;
            if (h > 8191)
                h = 8191;
            jit  = h;
            bx   = 0;
            by   = 0;
            bz   = 0;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                kind = SK_STILL;
                len  = 1 + $urandom_range(0, int'(sb.regs.window) + int'(sb.regs.cooldown) + 4);
                // A quiet stretch averages below two, so its window closes
                // without a rezero; otherwise each axis gets a bias.
                if ($urandom_range(0, 3) == 0)
                    jit = (h > 0) ? 1 : 0;
                else begin
                    bx = srand(h);
                    by = srand(h);
                    bz = srand(h);
                end
            end
            else if (pick < 70) begin
                kind = SK_LOW;
                len  = 1 + $urandom_range(0, int'(sb.regs.ff_need) + 2);
            end
            else if (pick < 80) begin
                kind = SK_HIGH;
                len  = 1 + $urandom_range(0, int'(sb.regs.motion_need) + 2);
            end
            else if (pick < 88) begin
                kind = SK_LOUD;
                len  = 1 + $urandom_range(0, 2);
            end
            else begin
                kind = SK_NOISE;
                len  = 1 + $urandom_range(0, 2);
            end
            if (len > 60)
                len = 60;
            if (len > n_items - sent)
                len = n_items - sent;
            send_burst(kind, len, bx, by, bz, jit);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_FREEFALL_LEVEL;
        cfg_wr_data        = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.payload  = '0;
        result_ch.ready    = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset registers. Zero acceleration is
        // low and below the band at once, so the second one shows motion
        // held back by free-fall.
        send_sample(mk(0, 0, 0, 0, 0, 0));
        send_sample(mk(0, 0, 0, 0, 0, 0));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(mk(0, 0, 16384, 32, 0, 0));
        send_sample(mk(0, 0, -16384, 0, -32, 0));
        // Gyro magnitude exactly at the still level is not still.
        send_sample(mk(16384, 0, 0, 33, 0, 0));
        // Upper band edge: on the edge is inside, one count above is not.
        send_sample(mk(20480, 0, 0, 0, 0, -19));
        send_sample(mk(20481, 0, 0, 0, 0, 0));
        send_sample(mk(0, 20481, 0, 0, 0, 0));
        // Lower band edge.
        send_sample(mk(12288, 0, 0, 0, 0, 0));
        send_sample(mk(0, 0, 12287, 0, 0, 0));
        // Free-fall edge: at the level is not low, one below is.
        send_sample(mk(6554, 0, 0, 0, 0, 0));
        send_sample(mk(6553, 0, 0, 0, 0, 0));
        send_sample(mk(0, 6553, 0, 0, 0, 0));
        send_sample(mk(0, 0, 16384, -32768, 32767, 0));
        send_sample(mk(0, 0, 16384, 0, 0, 0));
        run_phase(20);
        drain();

        // Single-sample events and a window that closes on every still
        // sample, with no idling on either side.
        steady = 1'b1;
        apply_cfg(6554, 16384, 4096, 200, 1, 1, 1, 0);
        run_phase(20);
        drain();

        // Zero sample counts: free-fall is declared on every sample.
        apply_cfg(3000, 16384, 2048, 100, 0, 0, 5, 0);
        run_phase(20);
        drain();
        steady = 1'b0;

        // A zero rest window behaves like a window of one.
        apply_cfg(5000, 16384, 3000, 120, 2, 3, 0, 2);
        run_phase(20);
        drain();

        // Band wider than one g: only the upper edge can cause motion.
        apply_cfg(1000, 4000, 4096, 80, 2, 2, 4, 1);
        run_phase(20);
        drain();

        // Every register at its maximum.
        apply_cfg(65535, 65535, 65535, 65535, 255, 255, 255, 255);
        run_phase(20);
        drain();

        // Every register at zero.
        apply_cfg(0, 0, 0, 0, 0, 0, 0, 0);
        run_phase(20);
        drain();

        // Run saturation: a long drop drives both run counters to their
        // limit, then full-scale shocks end the drop while the off-band run
        // stays saturated, so motion appears with the longest count.
        apply_cfg(40000, 16384, 0, 33, 255, 255, 3, 0);
        send_burst(SK_LOW, 260, 0, 0, 0, 0);
        send_burst(SK_LOUD, 5, 0, 0, 0, 0);
        run_phase(10);
        drain();

        // Typical settings drawn at random.
        repeat (4) begin
            apply_cfg($urandom_range(3000, 9000), $urandom_range(14000, 18000),
                      $urandom_range(1000, 6000), $urandom_range(20, 400),
                      $urandom_range(1, 5), $urandom_range(1, 5),
                      $urandom_range(1, 12), $urandom_range(0, 20));
            run_phase(20);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/imu_ffr_pkg.sv
src/imu_ffr_stream_if.sv
src/imu_ffr_lane.sv
src/imu_ffr_merge.sv
src/imu_freefall_motion_rest_rezero.sv
tb/sv/tb_top.sv
